// ===== design/scta_pkg.sv =====
// scta_pkg: shared constants and key tables for the scan code decoder
// no dependencies; imported by scta_keymap and scan_code_to_ascii_fifo_top

package scta_pkg;

    // set-1 codes of interest
    localparam logic [7:0] MAKE_LSHIFT  = 8'h2A;
    localparam logic [7:0] MAKE_RSHIFT  = 8'h36;
    localparam logic [7:0] BREAK_BIT    = 8'h80;
    localparam logic [7:0] BREAK_LSHIFT = MAKE_LSHIFT | BREAK_BIT;
    localparam logic [7:0] BREAK_RSHIFT = MAKE_RSHIFT | BREAK_BIT;
    localparam logic [7:0] FIRST_BREAK  = 8'h81;
    localparam int         TABLE_LEN    = 83;
    localparam logic [7:0] LAST_BREAK   = 8'(FIRST_BREAK + TABLE_LEN - 1);
    localparam int         KEY_IDX_W    = $clog2(TABLE_LEN);

    typedef logic [7:0] t_char;

    // characters for break codes 0x81 upwards, unshifted
    localparam t_char KEY_MAP_PLAIN [TABLE_LEN] = '{
        8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
        8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61,
        8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27,
        8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
        8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00
    };

    // characters with shift held
    localparam t_char KEY_MAP_SHIFT [TABLE_LEN] = '{
        8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28,
        8'h29, 8'h5F, 8'h2B, 8'h08, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
        8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41,
        8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22,
        8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
        8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32,
        8'h33, 8'h30, 8'h2E
    };

endpackage

// ===== design/scta_keymap.sv =====
// scta_keymap: shift flag update and break code to character lookup
// depends on scta_pkg for the code constants and key tables

module scta_keymap (
    input  logic          [7:0] i_code,
    input  logic                i_shift_held,
    output logic                o_shift_next,
    output scta_pkg::t_char     o_char
);
    import scta_pkg::*;

    logic [KEY_IDX_W-1:0] key_idx;
    logic                 in_range;

    // shift make sets the flag, matching break clears it
    always_comb begin
        o_shift_next = i_shift_held;
        if (i_code == MAKE_LSHIFT || i_code == MAKE_RSHIFT) begin
            o_shift_next = 1'b1;
        end
        if (i_code == BREAK_LSHIFT || i_code == BREAK_RSHIFT) begin
            o_shift_next = 1'b0;
        end
    end

    // table index for break codes inside the mapped range
    assign key_idx  = KEY_IDX_W'(i_code - FIRST_BREAK);
    assign in_range = (i_code >= FIRST_BREAK) && (i_code <= LAST_BREAK);

    // lookup with the updated shift state
    always_comb begin
        if (!in_range) begin
            o_char = '0;
        end else if (o_shift_next) begin
            o_char = KEY_MAP_SHIFT[key_idx];
        end else begin
            o_char = KEY_MAP_PLAIN[key_idx];
        end
    end

endmodule

// ===== design/scan_code_to_ascii_fifo_top.sv =====
// scan_code_to_ascii_fifo_top: set-1 scan code decoder with a character queue
// depends on scta_pkg and scta_keymap
//
// Usage: each input transfer carries i_command and i_scan_code. Command 0
// hands in a raw set-1 scan code; while the queue is not full it updates the
// shift flag and a mapped break code pushes its character. Command 1 pops the
// oldest character, or returns 0 with o_char_valid low when the queue is
// empty. Every input transfer yields exactly one output transfer carrying
// o_read_char, o_char_valid, o_stored and o_queue_count (fill after the item).
// The result appears in the output register on the cycle after acceptance,
// the popped byte coming from the registered read port of the queue memory.
// Throughput is one item per cycle while no held result is stalled, with a
// read-modify-write of the pointers and fill count around the one-port
// character memory for each item. When the receiver stalls with a result held,
// o_in_stall rises and no item is taken until that result is transferred.
// Reset clears the shift flag, both pointers, the fill count and the output
// valid; the queue memory itself is not cleared, as only written entries
// are ever popped.

module scan_code_to_ascii_fifo_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic [7:0]                         i_scan_code,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_read_char,
    output logic                               o_char_valid,
    output logic                               o_stored,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_queue_count
);
    import scta_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // control state
    logic             r_shift_held, n_shift_held;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_out_valid;

    // result payload
    logic             r_char_valid;
    logic             r_stored;
    logic [CNT_W-1:0] r_count;
    t_char            r_rdata;

    // queue memory
    t_char            r_queue [QUEUE_DEPTH];

    logic             accept;
    logic             queue_full;
    logic             scan_ok;
    logic             do_write;
    logic             do_read;
    logic             shift_next;
    t_char            key_char;

    scta_keymap u_keymap (
        .i_code       (i_scan_code),
        .i_shift_held (r_shift_held),
        .o_shift_next (shift_next),
        .o_char       (key_char)
    );

    // handshake: take an item unless a held result is being stalled
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // queue operation decode
    assign queue_full = (r_fill == CNT_FULL);
    assign scan_ok    = accept & ~i_command & ~queue_full;
    assign do_write   = scan_ok & (key_char != '0);
    assign do_read    = accept & i_command & (r_fill != '0);

    // next pointers, fill count and shift flag
    always_comb begin
        n_shift_held = scan_ok ? shift_next : r_shift_held;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_fill       = r_fill;
        if (do_write) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
        if (do_read) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_shift_held <= n_shift_held;
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_fill       <= n_fill;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // memory write and registered read; read data holds while stalled
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_queue[r_wr_ptr] <= key_char;
        end
        if (do_read) begin
            r_rdata <= r_queue[r_rd_ptr];
        end
    end

    // result payload captured on each input transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char_valid <= do_read;
            r_stored     <= do_write;
            r_count      <= n_fill;
        end
    end

    // output fields
    assign o_out_valid   = r_out_valid;
    assign o_read_char   = r_char_valid ? r_rdata : '0;
    assign o_char_valid  = r_char_valid;
    assign o_stored      = r_stored;
    assign o_queue_count = r_count;

endmodule
